/* sv/ita2rf_pkg.sv */
// ----------------------------------------------------------------------------
// ita2rf_pkg
// Shared types, line codes and the character encoder for the ITA2 framer.
// ----------------------------------------------------------------------------
package ita2rf_pkg;

	typedef logic [4:0] code_t;

	// line codes
	localparam code_t CODE_FIGS  = 5'd27;
	localparam code_t CODE_LTRS  = 5'd31;
	localparam code_t CODE_SPACE = 5'h04;

	// lower to upper case distance
	localparam logic [7:0] CASE_FOLD = 8'd32;

	// symbol positions inside one frame
	localparam logic [2:0] SYM_START = 3'd0;
	localparam logic [2:0] SYM_STOP  = 3'd6;
	localparam logic [2:0] SYM_MSB   = 3'd5;

	// symbol durations in half-bit units
	localparam logic [1:0] LEN_BIT  = 2'd2;
	localparam logic [1:0] LEN_STOP = 2'd3;

	// one queued character: up to four codes, sent from index 0
	typedef struct packed {
		logic [3:0][4:0] codes;
		logic [1:0]      last_idx;
	} job_t;

	// classification of one input character
	typedef struct packed {
		logic  found;
		logic  is_space;
		logic  want_figs;
		code_t code;
	} char_class_t;

	// letters-case code for key A (0) to Z (25)
	function automatic code_t letter_code(input logic [4:0] idx);
		code_t c;
		case (idx)
			5'd0:    c = 5'h18;
			5'd1:    c = 5'h13;
			5'd2:    c = 5'h0E;
			5'd3:    c = 5'h12;
			5'd4:    c = 5'h10;
			5'd5:    c = 5'h16;
			5'd6:    c = 5'h0B;
			5'd7:    c = 5'h05;
			5'd8:    c = 5'h0C;
			5'd9:    c = 5'h1A;
			5'd10:   c = 5'h1E;
			5'd11:   c = 5'h09;
			5'd12:   c = 5'h07;
			5'd13:   c = 5'h06;
			5'd14:   c = 5'h03;
			5'd15:   c = 5'h0D;
			5'd16:   c = 5'h1D;
			5'd17:   c = 5'h0A;
			5'd18:   c = 5'h14;
			5'd19:   c = 5'h01;
			5'd20:   c = 5'h1C;
			5'd21:   c = 5'h0F;
			5'd22:   c = 5'h19;
			5'd23:   c = 5'h17;
			5'd24:   c = 5'h15;
			5'd25:   c = 5'h11;
			default: c = 5'h00;
		endcase
		return c;
	endfunction

	// map an ascii character to its code and required case
	function automatic char_class_t classify(input logic [7:0] ch);
		char_class_t r;
		logic [7:0]  up;
		logic [4:0]  fig_idx;
		logic        fig_hit;
		r       = '0;
		up      = ch;
		fig_idx = 5'd0;
		fig_hit = 1'b1;
		if (ch inside {[8'h61:8'h7A]}) begin
			up = ch - CASE_FOLD;
		end
		// figures set, by letter key (the apostrophe takes the J key)
		case (up)
			8'h2D:   fig_idx = 5'd0;
			8'h3F:   fig_idx = 5'd1;
			8'h3A:   fig_idx = 5'd2;
			8'h24:   fig_idx = 5'd3;
			8'h33:   fig_idx = 5'd4;
			8'h21:   fig_idx = 5'd5;
			8'h26:   fig_idx = 5'd6;
			8'h23:   fig_idx = 5'd7;
			8'h38:   fig_idx = 5'd8;
			8'h27:   fig_idx = 5'd9;
			8'h28:   fig_idx = 5'd10;
			8'h29:   fig_idx = 5'd11;
			8'h2E:   fig_idx = 5'd12;
			8'h2C:   fig_idx = 5'd13;
			8'h39:   fig_idx = 5'd14;
			8'h30:   fig_idx = 5'd15;
			8'h31:   fig_idx = 5'd16;
			8'h34:   fig_idx = 5'd17;
			8'h35:   fig_idx = 5'd19;
			8'h37:   fig_idx = 5'd20;
			8'h3B:   fig_idx = 5'd21;
			8'h32:   fig_idx = 5'd22;
			8'h2F:   fig_idx = 5'd23;
			8'h36:   fig_idx = 5'd24;
			8'h22:   fig_idx = 5'd25;
			default: fig_hit = 1'b0;
		endcase
		if (up inside {[8'h41:8'h5A]}) begin
			r.found = 1'b1;
			r.code  = letter_code(up[4:0] - 5'd1);
		end else if (up == 8'h20) begin
			r.found    = 1'b1;
			r.is_space = 1'b1;
			r.code     = CODE_SPACE;
		end else if (fig_hit) begin
			r.found     = 1'b1;
			r.want_figs = 1'b1;
			r.code      = letter_code(fig_idx);
		end
		return r;
	endfunction

endpackage

/* sv/ita2_rtty_character_framer.sv */
// ----------------------------------------------------------------------------
// ita2_rtty_character_framer
// ASCII to ITA2 RTTY line symbol framer.
// ----------------------------------------------------------------------------
// Usage:
//   The char channel (char_valid/char_stall) takes one ASCII character per
//   transfer with message_first/message_last flags. The sym channel
//   (sym_valid/sym_stall) delivers line symbols: tone_mark, the duration in
//   half bits (2 for start/data, 3 for stop) and run_last on the final
//   symbol of a character.
//   Each code is a 7-symbol frame; a character yields 0 to 4 frames, so 0,
//   7, 14, 21 or 28 symbols. The symbol generator emits one symbol per cycle
//   while sym_stall is low; the first symbol of a character passes through a
//   queue entry and then the output register.
//   A two-entry job queue lets the input take new characters while earlier
//   ones are still being sent; a character with no symbols gets no entry.
//   When sym_stall is high the output register holds its symbol and the
//   queue fills; char_stall rises once both queue entries are in use.
//   Reset clears the queue, the output stage and sets the shift to letters.
// ----------------------------------------------------------------------------
module ita2_rtty_character_framer import ita2rf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       message_first,
	input  logic       message_last,
	output logic       sym_valid,
	input  logic       sym_stall,
	output logic       tone_mark,
	output logic [1:0] length_half_bits,
	output logic       run_last
);

	logic push;
	job_t push_job;
	logic queue_full;
	logic pop;
	job_t head;
	logic head_valid;

	// character intake and shift tracking
	ita2rf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_code     (char_code),
		.message_first (message_first),
		.message_last  (message_last),
		.queue_full    (queue_full),
		.push          (push),
		.push_job      (push_job)
	);

	// decoupling queue
	ita2rf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// symbol generator
	ita2rf_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.head_valid       (head_valid),
		.pop              (pop),
		.sym_valid        (sym_valid),
		.sym_stall        (sym_stall),
		.tone_mark        (tone_mark),
		.length_half_bits (length_half_bits),
		.run_last         (run_last)
	);

endmodule

/* sv/ita2rf_front.sv */
// ----------------------------------------------------------------------------
// ita2rf_front
// Accepts characters, tracks the letters/figures shift and builds the list
// of codes that one character needs.
// ----------------------------------------------------------------------------
module ita2rf_front import ita2rf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       message_first,
	input  logic       message_last,
	input  logic       queue_full,
	output logic       push,
	output job_t       push_job
);

	logic        figures_shift_q;
	logic        accept;
	logic        shift_base;
	logic        shift_next;
	char_class_t cls;
	logic [2:0]  n_codes;

	assign char_stall = queue_full;
	assign accept     = char_valid && !queue_full;

	// classify and build the code list
	always_comb begin
		cls        = classify(char_code);
		shift_base = message_first ? 1'b0 : figures_shift_q;
		shift_next = shift_base;
		push_job   = '0;
		n_codes    = 3'd0;
		if (message_first) begin
			push_job.codes[n_codes[1:0]] = CODE_LTRS;
			n_codes = n_codes + 3'd1;
		end
		if (cls.found) begin
			if (!cls.is_space && (cls.want_figs != shift_base)) begin
				push_job.codes[n_codes[1:0]] = cls.want_figs ? CODE_FIGS : CODE_LTRS;
				n_codes    = n_codes + 3'd1;
				shift_next = cls.want_figs;
			end
			push_job.codes[n_codes[1:0]] = cls.code;
			n_codes = n_codes + 3'd1;
		end
		if (message_last) begin
			push_job.codes[n_codes[1:0]] = CODE_LTRS;
			n_codes = n_codes + 3'd1;
		end
		push_job.last_idx = n_codes[1:0] - 2'd1;
	end

	// characters that yield no symbols are consumed without a queue entry
	assign push = accept && (n_codes != 3'd0);

	// shift state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			figures_shift_q <= 1'b0;
		end else if (accept) begin
			figures_shift_q <= shift_next;
		end
	end

endmodule

/* sv/ita2rf_queue.sv */
// ----------------------------------------------------------------------------
// ita2rf_queue
// Two-entry job queue between the front and the symbol generator.
// ----------------------------------------------------------------------------
module ita2rf_queue import ita2rf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic head_valid
);

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue fill level out of range");
`endif

endmodule

/* sv/ita2rf_back.sv */
// ----------------------------------------------------------------------------
// ita2rf_back
// Walks the queued codes frame by frame and emits one line symbol per
// cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ita2rf_back import ita2rf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       head_valid,
	output logic       pop,
	output logic       sym_valid,
	input  logic       sym_stall,
	output logic       tone_mark,
	output logic [1:0] length_half_bits,
	output logic       run_last
);

	logic [1:0] frame_q;
	logic [2:0] sym_q;
	logic       valid_q;
	logic       tone_q;
	logic [1:0] len_q;
	logic       last_q;
	logic       advance;
	code_t      cur_code;
	logic       last_sym;
	logic       last_frame;
	logic       tone_next;
	logic [1:0] len_next;

	assign sym_valid        = valid_q;
	assign tone_mark        = tone_q;
	assign length_half_bits = len_q;
	assign run_last         = last_q;

	// output stage free or draining this cycle
	assign advance    = head_valid && (!valid_q || !sym_stall);
	assign cur_code   = head.codes[frame_q];
	assign last_sym   = (sym_q == SYM_STOP);
	assign last_frame = (frame_q == head.last_idx);
	assign pop        = advance && last_sym && last_frame;

	// symbol of the current frame position
	always_comb begin
		len_next = LEN_BIT;
		case (sym_q)
			SYM_START: tone_next = 1'b0;
			SYM_STOP: begin
				tone_next = 1'b1;
				len_next  = LEN_STOP;
			end
			default:   tone_next = cur_code[SYM_MSB - sym_q];
		endcase
	end

	// frame and symbol counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= 2'd0;
			sym_q   <= SYM_START;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
			if (last_sym) begin
				sym_q   <= SYM_START;
				frame_q <= last_frame ? 2'd0 : frame_q + 2'd1;
			end else begin
				sym_q <= sym_q + 3'd1;
			end
		end else if (!sym_stall) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			tone_q <= tone_next;
			len_q  <= len_next;
			last_q <= last_sym && last_frame;
		end
	end

`ifndef NO_ASSERTIONS
	a_last_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && last_q |-> (len_q == LEN_STOP) && tone_q)
		else $error("run end flagged on a symbol other than a stop bit");
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> frame_q <= head.last_idx)
		else $error("frame index beyond the queued code count");
	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (frame_q == 2'd0) && (sym_q == SYM_START))
		else $error("symbol counters not at rest with an empty queue");
	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		sym_q <= SYM_STOP)
		else $error("symbol position out of range");
`endif

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the ITA2 RTTY character framer. Characters go in over the
// char channel; a predictor in the bench expands each accepted one into
// its line symbols. Every symbol transfer is checked in order against the
// predicted stream. Both channels see random idle gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top import ita2rf_pkg::*;;

	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int unsigned RANDOM_ITEMS = 200;

	// letters-case code for keys A to Z
	localparam code_t KEY_CODE [26] = '{
		5'h18, 5'h13, 5'h0E, 5'h12, 5'h10, 5'h16, 5'h0B, 5'h05, 5'h0C, 5'h1A,
		5'h1E, 5'h09, 5'h07, 5'h06, 5'h03, 5'h0D, 5'h1D, 5'h0A, 5'h14, 5'h01,
		5'h1C, 5'h0F, 5'h19, 5'h17, 5'h15, 5'h11
	};

	// figures-case character on keys A to Z (apostrophe twice, J wins)
	localparam logic [7:0] FIGURE_KEY [26] = '{
		"-", "?", ":", "$", "3", "!", "&", "#", "8", "'",
		"(", ")", ".", ",", "9", "0", "1", "4", "'", "5",
		"7", ";", "2", "/", "6", "\""
	};

	typedef struct packed {
		logic       tone_mark;
		logic [1:0] length_half_bits;
		logic       run_last;
	} line_sym_t;

	typedef struct packed {
		logic  found;
		logic  is_space;
		logic  want_figs;
		code_t code;
	} char_map_t;

	logic       clk;
	logic       arst_n;
	logic       char_valid;
	logic       char_stall;
	logic [7:0] char_code;
	logic       message_first;
	logic       message_last;
	logic       sym_valid;
	logic       sym_stall;
	logic       tone_mark;
	logic [1:0] length_half_bits;
	logic       run_last;

	line_sym_t   expected_symbols[$];
	logic        figs_shift;
	int unsigned mismatches;
	int unsigned cycle_count;
	logic        no_idle;

	ita2_rtty_character_framer dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.char_valid       (char_valid),
		.char_stall       (char_stall),
		.char_code        (char_code),
		.message_first    (message_first),
		.message_last     (message_last),
		.sym_valid        (sym_valid),
		.sym_stall        (sym_stall),
		.tone_mark        (tone_mark),
		.length_half_bits (length_half_bits),
		.run_last         (run_last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// idle length: mostly none, sometimes short, rarely long
	function automatic int unsigned idle_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// ascii character to code and case
	function automatic char_map_t map_ascii(input logic [7:0] ch);
		char_map_t  m;
		logic [7:0] up;
		m  = '0;
		up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
		if (up >= "A" && up <= "Z") begin
			m.found = 1'b1;
			m.code  = KEY_CODE[up - "A"];
		end else if (up == " ") begin
			m.found    = 1'b1;
			m.is_space = 1'b1;
			m.code     = CODE_SPACE;
		end else if (up != 8'h00 && up < 8'h80) begin
			for (int i = 0; i < 26; i++) begin
				if (!m.found && FIGURE_KEY[i] == up) begin
					m.found     = 1'b1;
					m.want_figs = 1'b1;
					m.code      = KEY_CODE[i];
				end
			end
		end
		return m;
	endfunction

	// expand one accepted character into its line symbols
	task automatic predict_symbols(input logic [7:0] ch, input logic first, input logic last);
		char_map_t m;
		code_t     codes[$];
		line_sym_t s;
		m = map_ascii(ch);
		if (first) begin
			figs_shift = 1'b0;
			codes.push_back(CODE_LTRS);
		end
		if (m.found) begin
			if (!m.is_space && m.want_figs != figs_shift) begin
				codes.push_back(m.want_figs ? CODE_FIGS : CODE_LTRS);
				figs_shift = m.want_figs;
			end
			codes.push_back(m.code);
		end
		if (last) begin
			codes.push_back(CODE_LTRS);
		end
		// start bit, five data bits msb first, long stop bit
		foreach (codes[k]) begin
			for (int b = 0; b < 7; b++) begin
				s.tone_mark        = (b == 0) ? 1'b0 : (b == 6) ? 1'b1 : codes[k][5 - b];
				s.length_half_bits = (b == 6) ? LEN_STOP : LEN_BIT;
				s.run_last         = (k == codes.size() - 1) && (b == 6);
				expected_symbols.push_back(s);
			end
		end
	endtask

	// one character transfer, with an optional idle gap ahead of it
	task automatic transmit_char(input logic [7:0] ch, input logic first, input logic last);
		int unsigned gap;
		gap = idle_length();
		if (gap != 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid    <= 1'b1;
		char_code     <= ch;
		message_first <= first;
		message_last  <= last;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		predict_symbols(ch, first, last);
	endtask

	// random character, weighted toward encodable ones
	function automatic logic [7:0] pick_message_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
			4, 5, 6:    return FIGURE_KEY[$urandom_range(0, 25)];
			7:          return " ";
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// letters from both cases, first flag from reset state
	task automatic test_letters();
		transmit_char("A", 1'b1, 1'b0);
		transmit_char("z", 1'b0, 1'b0);
		transmit_char("m", 1'b0, 1'b0);
	endtask

	// shifts into and out of figures, apostrophe on the J key
	task automatic test_figures();
		transmit_char("-", 1'b0, 1'b0);
		transmit_char("\"", 1'b0, 1'b0);
		transmit_char("'", 1'b0, 1'b0);
		transmit_char("Q", 1'b0, 1'b0);
	endtask

	// space sends no shift code and keeps the case
	task automatic test_space();
		transmit_char(" ", 1'b0, 1'b0);
		transmit_char("5", 1'b0, 1'b0);
		transmit_char(" ", 1'b0, 1'b0);
		transmit_char("E", 1'b0, 1'b0);
	endtask

	// unencodable characters, with and without the flag codes
	task automatic test_unencodable();
		transmit_char(8'h00, 1'b1, 1'b1);
		transmit_char(8'hFF, 1'b0, 1'b0);
		transmit_char(8'h80, 1'b0, 1'b1);
		transmit_char("@", 1'b0, 1'b0);
		transmit_char(8'h7F, 1'b1, 1'b0);
	endtask

	// largest output: leading ltrs, figs, character, trailing ltrs
	task automatic test_message_flags();
		transmit_char("8", 1'b0, 1'b0);
		transmit_char("?", 1'b1, 1'b1);
		transmit_char("a", 1'b0, 1'b1);
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		no_idle = 1'b1;
		for (int i = 0; i < 6; i++) begin
			transmit_char(pick_message_char(), i == 0, i == 5);
		end
		no_idle = 1'b0;
	endtask

	// mostly framed messages with random content, some raw noise
	task automatic test_random_messages();
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			len = $urandom_range(1, 12);
			if ($urandom_range(0, 99) < 85) begin
				for (int i = 0; i < len; i++) begin
					transmit_char(pick_message_char(), i == 0, i == len - 1);
				end
			end else begin
				for (int i = 0; i < len; i++) begin
					transmit_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end
			end
			sent += len;
		end
	endtask

	// output stall pattern
	initial begin : sym_stall_drive
		int unsigned run;
		sym_stall <= 1'b0;
		forever begin
			@(posedge clk);
			run = idle_length();
			if (run != 0) begin
				sym_stall <= 1'b1;
				repeat (run) @(posedge clk);
				sym_stall <= 1'b0;
			end
		end
	end

	// compare each symbol transfer with the oldest prediction
	always @(posedge clk) begin : symbol_check
		line_sym_t want;
		if (sym_valid && !sym_stall) begin
			if (expected_symbols.size() == 0) begin
				$error("unexpected symbol: tone_mark %0d length_half_bits %0d run_last %0d",
					tone_mark, length_half_bits, run_last);
				mismatches++;
			end else begin
				want = expected_symbols.pop_front();
				if (tone_mark !== want.tone_mark) begin
					$error("tone_mark: expected %0d, actual %0d", want.tone_mark, tone_mark);
					mismatches++;
				end
				if (length_half_bits !== want.length_half_bits) begin
					$error("length_half_bits: expected %0d, actual %0d",
						want.length_half_bits, length_half_bits);
					mismatches++;
				end
				if (run_last !== want.run_last) begin
					$error("run_last: expected %0d, actual %0d", want.run_last, run_last);
					mismatches++;
				end
			end
		end
	end

	// timeout
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// test sequence
	initial begin : main_sequence
		mismatches    = 0;
		figs_shift    = 1'b0;
		no_idle       = 1'b0;
		arst_n        <= 1'b0;
		char_valid    <= 1'b0;
		char_code     <= 8'h00;
		message_first <= 1'b0;
		message_last  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_letters();
		test_figures();
		test_space();
		test_unencodable();
		test_message_flags();
		test_back_to_back();
		test_random_messages();
		char_valid <= 1'b0;

		// drain, then allow for any symbol still in flight
		while (expected_symbols.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_symbols.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
